FILE: rtl/rit_pkg.sv
// shared types and command codes of the reload interval timer
package rit_pkg;

   localparam int unsigned KIND_W = 3;
   localparam int unsigned TIME_W = 32;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam kind_type KIND_TICK       = 3'd0;
   localparam kind_type KIND_CHECK      = 3'd1;
   localparam kind_type KIND_START      = 3'd2;
   localparam kind_type KIND_SET        = 3'd3;
   localparam kind_type KIND_SET_RELOAD = 3'd4;
   localparam kind_type KIND_TRIGGER    = 3'd5;
   localparam kind_type KIND_READ       = 3'd6;

   typedef struct packed {
      kind_type kind;
      time_type value;
      logic     flag;
   } req_type;

   typedef struct packed {
      logic     fired;
      time_type remaining;
      time_type now_time;
   } rsp_type;

endpackage

FILE: rtl/rit_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
interface rit_stream_if #(
   parameter type data_type = rit_pkg::req_type
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/reload_interval_timer_top.sv
// reload interval timer: command register, state update, snapshot, result register
// each result reaches rsp_if via the snapshot stage and the result register
// throughput: one command per cycle unless stalled; the state update between the
//    command register and snapshot stage is one 32-bit subtract, compare and add
// backpressure: each stage holds while the stage after it is full and stalled,
//    so a new command is taken while a finished result waits to be transferred
// reset: synchronous, active high; clears all stage valids and the timer state,
//    leaving a disabled timer with zero time base and accurate_mode 0
module reload_interval_timer_top (
   input  logic                clock,
   input  logic                reset,
   rit_stream_if.sink          req_if,
   rit_stream_if.source        rsp_if,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   // ---------------------------------------------------------------- control
   // stage valids: s1 = command register, s2 = post-update snapshot, out = result
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;

   logic rdy_out, rdy_s2, rdy_s1;
   logic s1_load, s2_load, out_load;

   // a stage can take new data when empty or when its own data moves on
   assign rdy_out = !out_v_ff || rsp_if.ready;
   assign rdy_s2  = !s2_v_ff || rdy_out;
   assign rdy_s1  = !s1_v_ff || rdy_s2;

   assign req_if.ready = rdy_s1;
   assign s1_load  = req_if.valid && rdy_s1;
   assign s2_load  = s1_v_ff && rdy_s2;
   assign out_load = s2_v_ff && rdy_out;

   always_comb begin
      s1_v_in  = s1_load || (s1_v_ff && !rdy_s2);
      s2_v_in  = s2_load || (s2_v_ff && !rdy_out);
      out_v_in = out_load || (out_v_ff && !rsp_if.ready);
   end

   // ---------------------------------------------------------------- command register
   rit_pkg::req_type s1_cmd_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_cmd_ff <= req_if.data;
      end
   end

   // ---------------------------------------------------------------- timer state
   logic              accurate_mode_ff;
   rit_pkg::time_type time_base_ff, time_base_in;
   rit_pkg::time_type start_mark_ff, start_mark_in;
   rit_pkg::time_type interval_ff, interval_in;
   rit_pkg::time_type reload_ff, reload_in;
   logic              armed_ff, armed_in;
   logic              fired_in;

   rit_pkg::time_type elapsed;
   logic              expired;
   logic              value_zero;

   // elapsed time wraps with the time base
   assign elapsed    = time_base_ff - start_mark_ff;
   assign expired    = armed_ff && (elapsed > interval_ff);
   assign value_zero = (s1_cmd_ff.value == '0);

   always_comb begin
      time_base_in  = time_base_ff;
      start_mark_in = start_mark_ff;
      interval_in   = interval_ff;
      reload_in     = reload_ff;
      armed_in      = armed_ff;
      fired_in      = 1'b0;

      unique case (s1_cmd_ff.kind)
         rit_pkg::KIND_TICK: begin
            time_base_in = time_base_ff + s1_cmd_ff.value;
         end
         rit_pkg::KIND_CHECK: begin
            if (expired) begin
               fired_in = 1'b1;
               if (s1_cmd_ff.flag) begin
                  // drift-free reload keeps the phase, else restart from now
                  start_mark_in = accurate_mode_ff ? (start_mark_ff + interval_ff)
                                                   : time_base_ff;
                  interval_in   = reload_ff;
               end else begin
                  armed_in = 1'b0;
               end
            end
         end
         rit_pkg::KIND_START: begin
            if (value_zero) begin
               armed_in = 1'b0;
            end else begin
               if (!armed_ff) begin
                  start_mark_in = time_base_ff;
               end
               interval_in = s1_cmd_ff.value;
               if (s1_cmd_ff.flag) begin
                  reload_in = s1_cmd_ff.value;
               end
               armed_in = 1'b1;
            end
         end
         rit_pkg::KIND_SET: begin
            if (!armed_ff) begin
               start_mark_in = time_base_ff;
               armed_in      = 1'b1;
            end
            if (!value_zero) begin
               interval_in = s1_cmd_ff.value;
               reload_in   = s1_cmd_ff.value;
            end
         end
         rit_pkg::KIND_SET_RELOAD: begin
            reload_in = s1_cmd_ff.value;
            if (s1_cmd_ff.flag) begin
               armed_in = 1'b1;
            end
         end
         rit_pkg::KIND_TRIGGER: begin
            // start = now - reload - 1, written as now + ~reload
            armed_in      = 1'b1;
            interval_in   = reload_ff;
            start_mark_in = time_base_ff + ~reload_ff;
         end
         default: begin
            // read and the unused code leave the state alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accurate_mode_ff <= 1'b0;
         time_base_ff     <= '0;
         start_mark_ff    <= '0;
         interval_ff      <= '0;
         reload_ff        <= '0;
         armed_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            accurate_mode_ff <= csr_wr_data;
         end
         if (s2_load) begin
            time_base_ff  <= time_base_in;
            start_mark_ff <= start_mark_in;
            interval_ff   <= interval_in;
            reload_ff     <= reload_in;
            armed_ff      <= armed_in;
         end
      end
   end

   // ---------------------------------------------------------------- snapshot stage
   // copy of the state as left by the command, for the remaining-time math
   logic              s2_fired_ff;
   logic              s2_armed_ff;
   rit_pkg::time_type s2_time_ff;
   rit_pkg::time_type s2_start_ff;
   rit_pkg::time_type s2_interval_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_fired_ff    <= fired_in;
         s2_armed_ff    <= armed_in;
         s2_time_ff     <= time_base_in;
         s2_start_ff    <= start_mark_in;
         s2_interval_ff <= interval_in;
      end
   end

   // ---------------------------------------------------------------- result stage
   rit_pkg::time_type s2_elapsed;
   rit_pkg::rsp_type  out_in;
   rit_pkg::rsp_type  out_ff;

   assign s2_elapsed = s2_time_ff - s2_start_ff;

   always_comb begin
      out_in.fired     = s2_fired_ff;
      out_in.now_time  = s2_time_ff;
      if (s2_armed_ff && (s2_elapsed < s2_interval_ff)) begin
         out_in.remaining = s2_interval_ff - s2_elapsed;
      end else begin
         out_in.remaining = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_if.valid = out_v_ff;
   assign rsp_if.data  = out_ff;

   // ---------------------------------------------------------------- assertions
   // only a check command can report a fire
   a_fired_only_on_check: assert property (@(posedge clock) disable iff (reset)
      s2_load && (s1_cmd_ff.kind != rit_pkg::KIND_CHECK) |=> !s2_fired_ff)
      else $error("fired set by a command other than check");

   // only a tick moves the time base
   a_time_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      s2_load && (s1_cmd_ff.kind != rit_pkg::KIND_TICK) |=> $stable(time_base_ff))
      else $error("time base changed by a command other than tick");

   // remaining time never exceeds the interval it was taken from
   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_ff.remaining <= $past(s2_interval_ff)))
      else $error("remaining exceeds interval");

   // a state update only happens when the snapshot stage takes the command
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s2_load |=> $stable(armed_ff) && $stable(start_mark_ff) && $stable(interval_ff))
      else $error("timer state changed without a command");

endmodule

FILE: tb/timer_result_checker.sv
// result checker for the reload interval timer: watches both channels, predicts and compares
module timer_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rit_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rit_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   output int unsigned       pending,
   output int unsigned       failures
);

   // predicted timer state
   rit_pkg::time_type tb_now;
   rit_pkg::time_type tb_mark;
   rit_pkg::time_type tb_span;
   rit_pkg::time_type tb_reload;
   logic              tb_armed;
   logic              tb_accurate;

   rit_pkg::rsp_type due_results[$];
   int unsigned      reported;

   initial begin
      pending  = 0;
      failures = 0;
      reported = 0;
   end

   function automatic rit_pkg::rsp_type advance_timer(rit_pkg::req_type cmd);
      rit_pkg::rsp_type  r;
      rit_pkg::time_type elapsed;
      r.fired = 1'b0;
      case (cmd.kind)
         rit_pkg::KIND_TICK: begin
            tb_now = tb_now + cmd.value;
         end
         rit_pkg::KIND_CHECK: begin
            elapsed = tb_now - tb_mark;
            if (tb_armed && elapsed > tb_span) begin
               if (cmd.flag) begin
                  tb_mark = tb_accurate ? tb_mark + tb_span : tb_now;
                  tb_span = tb_reload;
               end else begin
                  tb_armed = 1'b0;
               end
               r.fired = 1'b1;
            end
         end
         rit_pkg::KIND_START: begin
            if (cmd.value == '0) begin
               tb_armed = 1'b0;
            end else begin
               if (!tb_armed) tb_mark = tb_now;
               tb_span = cmd.value;
               if (cmd.flag) tb_reload = cmd.value;
               tb_armed = 1'b1;
            end
         end
         rit_pkg::KIND_SET: begin
            if (!tb_armed) begin
               tb_mark  = tb_now;
               tb_armed = 1'b1;
            end
            if (cmd.value != '0) begin
               tb_span   = cmd.value;
               tb_reload = cmd.value;
            end
         end
         rit_pkg::KIND_SET_RELOAD: begin
            tb_reload = cmd.value;
            if (cmd.flag) tb_armed = 1'b1;
         end
         rit_pkg::KIND_TRIGGER: begin
            tb_armed = 1'b1;
            tb_span  = tb_reload;
            tb_mark  = tb_now - tb_span - 32'd1;
         end
         default: begin
         end
      endcase
      elapsed     = tb_now - tb_mark;
      r.remaining = (tb_armed && elapsed < tb_span) ? tb_span - elapsed : '0;
      r.now_time  = tb_now;
      return r;
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (reported < 10) begin
         reported++;
         $display("mismatch: %s", msg);
      end
   endtask

   always @(posedge clock) begin
      rit_pkg::rsp_type want;
      if (reset) begin
         tb_now      = '0;
         tb_mark     = '0;
         tb_span     = '0;
         tb_reload   = '0;
         tb_armed    = 1'b0;
         tb_accurate = 1'b0;
         due_results.delete();
      end else begin
         // results leave before the command of this edge joins the queue
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               note_failure($sformatf("result with none due: fired %0b remaining %h now %h",
                                      rsp_data.fired, rsp_data.remaining, rsp_data.now_time));
            end else begin
               want = due_results.pop_front();
               if (rsp_data.fired !== want.fired)
                  note_failure($sformatf("fired expected %0b got %0b",
                                         want.fired, rsp_data.fired));
               if (rsp_data.remaining !== want.remaining)
                  note_failure($sformatf("remaining expected %h got %h",
                                         want.remaining, rsp_data.remaining));
               if (rsp_data.now_time !== want.now_time)
                  note_failure($sformatf("now_time expected %h got %h",
                                         want.now_time, rsp_data.now_time));
            end
         end
         if (csr_wr_en) tb_accurate = csr_wr_data;
         if (req_valid && req_ready) due_results.push_back(advance_timer(req_data));
      end
      pending <= due_results.size();
   end

endmodule

FILE: tb/testbench.sv
// testbench top for the reload interval timer: clock, reset, stimulus and verdict
module testbench;

   // kind code the block must treat as a no-op
   localparam rit_pkg::kind_type KIND_SPARE = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   int unsigned pending;
   int unsigned failures;

   // receiver hold-off requests, served by the receiver process
   int unsigned hold_asks;
   int unsigned hold_served;

   rit_stream_if #(.data_type(rit_pkg::req_type)) req_chan ();
   rit_stream_if #(.data_type(rit_pkg::rsp_type)) rsp_chan ();

   reload_interval_timer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   timer_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_data    (req_chan.data),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_chan.data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // safety net: far beyond the slowest legal run
   initial begin
      #3000000;
      $display("reload_interval_timer_top test failed");
      $finish;
   end

   function automatic rit_pkg::req_type cmd(rit_pkg::kind_type kind, rit_pkg::time_type value,
                                            logic flag);
      rit_pkg::req_type c;
      c.kind  = kind;
      c.value = value;
      c.flag  = flag;
      return c;
   endfunction

   // mostly small durations and ticks so checks fire often, plus the extremes
   function automatic rit_pkg::req_type random_command();
      int unsigned       pick;
      int unsigned       vpick;
      rit_pkg::kind_type kind;
      rit_pkg::time_type value;
      logic              flag;
      pick = $urandom_range(0, 99);
      if (pick < 30)      kind = rit_pkg::KIND_TICK;
      else if (pick < 58) kind = rit_pkg::KIND_CHECK;
      else if (pick < 68) kind = rit_pkg::KIND_START;
      else if (pick < 76) kind = rit_pkg::KIND_SET;
      else if (pick < 84) kind = rit_pkg::KIND_SET_RELOAD;
      else if (pick < 90) kind = rit_pkg::KIND_TRIGGER;
      else if (pick < 96) kind = rit_pkg::KIND_READ;
      else                kind = KIND_SPARE;
      vpick = $urandom_range(0, 99);
      if (vpick < 8)                       value = $urandom;
      else if (vpick < 12)                 value = '0;
      else if (vpick < 15)                 value = 32'hFFFF_FFFF;
      else if (vpick < 18)                 value = 32'h8000_0000 + $urandom_range(0, 2) - 1;
      else if (kind == rit_pkg::KIND_TICK) value = $urandom_range(0, 40);
      else                                 value = $urandom_range(1, 250);
      // checks mostly reload so the timer keeps running
      if (kind == rit_pkg::KIND_CHECK) flag = ($urandom_range(0, 3) != 0);
      else                             flag = ($urandom_range(0, 1) != 0);
      return cmd(kind, value, flag);
   endfunction

   // called at a clock edge; returns at the edge where the transfer happens
   task automatic offer(rit_pkg::req_type item);
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // sender stops and waits until every expected result has been seen
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // accurate_mode write, only ever issued while the block is idle
   task automatic write_mode(logic accurate);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= accurate;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random commands in bursts; a held phase asks the receiver for a long
   // hold-off and offers its first 60 commands back to back so the pipeline backs up
   task automatic random_phase(int unsigned count, bit with_gaps, bit hold);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      if (hold) hold_asks++;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int unsigned k = 0; k < burst && sent < count; k++) begin
            offer(random_command());
            sent++;
         end
         if (with_gaps && !(hold && sent < 60) && $urandom_range(0, 1) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // receiver: style rotates through four ready patterns, long hold-offs on request
   initial begin
      int unsigned cyc;
      int unsigned style;
      int unsigned hold_left;
      rsp_chan.ready = 1'b0;
      hold_served    = 0;
      cyc            = 0;
      hold_left      = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_served != hold_asks) begin
            hold_served++;
            hold_left = 80;
         end
         style = (cyc / 64) % 4;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= (cyc % 4 != 3);
               2: rsp_chan.ready <= ($urandom_range(0, 1) != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
         cyc++;
      end
   end

   // stimulus
   initial begin
      rit_pkg::req_type plan[$];
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      hold_asks      = 0;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass, reload from now
      write_mode(1'b0);
      plan.push_back(cmd(rit_pkg::KIND_READ,       32'd0,         1'b0)); // fresh timer
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b1)); // check while disarmed
      plan.push_back(cmd(rit_pkg::KIND_START,      32'd0,         1'b1)); // zero start disarms
      plan.push_back(cmd(rit_pkg::KIND_START,      32'd100,       1'b1)); // idle start, reload
      plan.push_back(cmd(rit_pkg::KIND_TICK,       32'd50,        1'b0));
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b1)); // not yet expired
      plan.push_back(cmd(rit_pkg::KIND_START,      32'd200,       1'b0)); // armed start keeps mark
      plan.push_back(cmd(rit_pkg::KIND_TICK,       32'd151,       1'b0));
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b1)); // fires and reloads
      plan.push_back(cmd(rit_pkg::KIND_SET_RELOAD, 32'hFFFF_FFFF, 1'b0));
      plan.push_back(cmd(rit_pkg::KIND_TRIGGER,    32'd0,         1'b0)); // all-ones interval
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b0)); // elapsed wrapped
      plan.push_back(cmd(rit_pkg::KIND_SET_RELOAD, 32'd10,        1'b1)); // enable while armed
      plan.push_back(cmd(rit_pkg::KIND_TRIGGER,    32'd0,         1'b0));
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b0)); // fires, one-shot
      plan.push_back(cmd(rit_pkg::KIND_SET,        32'd0,         1'b0)); // idle set, zero
      plan.push_back(cmd(rit_pkg::KIND_SET,        32'hFFFF_FFFF, 1'b1));
      plan.push_back(cmd(rit_pkg::KIND_TICK,       32'hFFFF_FFFF, 1'b1)); // time base wraps
      plan.push_back(cmd(KIND_SPARE,               32'hFFFF_FFFF, 1'b1)); // unused kind
      plan.push_back(cmd(rit_pkg::KIND_START,      32'd0,         1'b0));
      plan.push_back(cmd(rit_pkg::KIND_SET_RELOAD, 32'd5,         1'b1)); // enable while idle
      plan.push_back(cmd(rit_pkg::KIND_TICK,       32'h8000_0000, 1'b0));
      plan.push_back(cmd(rit_pkg::KIND_CHECK,      32'd0,         1'b1));
      plan.push_back(cmd(rit_pkg::KIND_SET,        32'd1,         1'b0));
      plan.push_back(cmd(rit_pkg::KIND_TICK,       32'd2,         1'b0));
      foreach (plan[i]) offer(plan[i]);
      drain();

      // random phases, drift-free and from-now reload alternating
      write_mode(1'b1);
      random_phase(240, 1'b1, 1'b1);
      drain();
      write_mode(1'b0);
      random_phase(240, 1'b0, 1'b0);
      drain();
      write_mode(1'b1);
      random_phase(240, 1'b1, 1'b1);
      drain();
      write_mode(1'b0);
      random_phase(230, 1'b1, 1'b0);
      drain();

      // tail: catch any stray result after the last expected one
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("reload_interval_timer_top test passed");
      end else begin
         $display("reload_interval_timer_top test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/rit_pkg.sv
rtl/rit_stream_if.sv
rtl/reload_interval_timer_top.sv
tb/timer_result_checker.sv
tb/testbench.sv
